// ----- hdl/alr_pkg.sv -----
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the line rasterizer
// Mode codes, fixed-point widths and the request record that passes from
// the load/classify front end to the stepping back end.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int CoordBits = 12;
  localparam int FracBits  = 16;
  localparam int PosBits   = CoordBits + FracBits + 2;   // minor position
  localparam int SlopeBits = FracBits + 2;
  localparam int StepBits  = CoordBits + 1;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_HSPAN  = 3'd1;
  localparam logic [2:0] MODE_VSPAN  = 3'd2;
  localparam logic [2:0] MODE_XMAJOR = 3'd3;
  localparam logic [2:0] MODE_YMAJOR = 3'd4;

  localparam logic [2:0] REG_SURF_W  = 3'd0;
  localparam logic [2:0] REG_SURF_H  = 3'd1;
  localparam logic [2:0] REG_CLIP_L  = 3'd2;
  localparam logic [2:0] REG_CLIP_T  = 3'd3;
  localparam logic [2:0] REG_CLIP_R  = 3'd4;
  localparam logic [2:0] REG_CLIP_B  = 3'd5;
  localparam logic [2:0] REG_ALPHA   = 3'd6;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic                          is_load;
    logic [2:0]                    mode;
    logic signed [CoordBits:0]     major;
    logic signed [PosBits-1:0]     minor;
    logic signed [SlopeBits-1:0]   slope;
    logic [StepBits-1:0]           steps;
  } alr_req_t;

  // Clip window, signed so an empty window compares correctly.
  typedef struct packed {
    logic signed [CoordBits+1:0] x0;
    logic signed [CoordBits+1:0] x1;
    logic signed [CoordBits+1:0] y0;
    logic signed [CoordBits+1:0] y1;
  } alr_win_t;

endpackage

// ----- hdl/antialiased_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: DDA line rasterizer with two-pixel coverage
// Front end classifies and clips loads, back end walks the line.
// ----------------------------------------------------------------------------
// The front end takes a request only while idle and holds it until the
// queue takes it, so it cannot accept a new one before the last has been
// handed on. In the back end a step that yields two fragments holds off
// the next request until its second fragment is in the output register,
// which sends one fragment per cycle while out_ready is high. A diagonal
// load holds the front end while the radix-2 slope divider produces 30
// quotient bits; a two-entry queue lets the back end keep stepping the
// previous line meanwhile. Configuration writes are taken at any time.
module antialiased_line_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [11:0] in_start_x,
  input  logic signed [11:0] in_start_y,
  input  logic signed [11:0] in_end_x,
  input  logic signed [11:0] in_end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_pixel_x,
  output logic [10:0]        out_pixel_y,
  output logic [7:0]         out_coverage_alpha,
  output logic               out_last,
  output logic               out_line_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  logic [11:0] sw_r, sh_r, cl_r, ct_r, cr_r, cb_r;
  logic [7:0]  al_r;
  alr_pkg::alr_win_t win;
  alr_pkg::alr_req_t fq_req, qb_req;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  logic signed [13:0] l, t, r, b, sw1, sh1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 12'd640; sh_r <= 12'd480;
      cl_r <= 12'd0;   ct_r <= 12'd0;
      cr_r <= 12'd2047; cb_r <= 12'd2047;
      al_r <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        alr_pkg::REG_SURF_W: sw_r <= cfg_data;
        alr_pkg::REG_SURF_H: sh_r <= cfg_data;
        alr_pkg::REG_CLIP_L: cl_r <= cfg_data;
        alr_pkg::REG_CLIP_T: ct_r <= cfg_data;
        alr_pkg::REG_CLIP_R: cr_r <= cfg_data;
        alr_pkg::REG_CLIP_B: cb_r <= cfg_data;
        alr_pkg::REG_ALPHA:  al_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    l   = 14'(signed'(cl_r));
    t   = 14'(signed'(ct_r));
    r   = 14'(signed'(cr_r));
    b   = 14'(signed'(cb_r));
    sw1 = signed'({2'b00, sw_r}) - 14'sd1;
    sh1 = signed'({2'b00, sh_r}) - 14'sd1;
    win.x0 = l < 0 ? 14'sd0 : l;
    win.y0 = t < 0 ? 14'sd0 : t;
    win.x1 = sw1 < r ? sw1 : r;
    win.y1 = sh1 < b ? sh1 : b;
  end

  alr_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .win(win), .req_valid(fq_valid), .req_ready(fq_ready), .req(fq_req)
  );

  alr_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_req),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_req)
  );

  alr_back u_back (
    .clk(clk), .rst_n(rst_n),
    .req_valid(qb_valid), .req_ready(qb_ready), .req(qb_req),
    .win(win), .alpha(al_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_coverage_alpha(out_coverage_alpha),
    .out_last(out_last), .out_line_done(out_line_done)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_last)
    else $error("line_done without last");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y))
    else $error("result changed while stalled");

endmodule

// ----- hdl/alr_div.sv -----
// ----------------------------------------------------------------------------
// alr_div: restoring divider for the slope
// Unsigned radix-2 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] num,
  input  logic [13:0] den,
  output logic        done,
  output logic [29:0] quot
);

  logic [29:0] q_r, q_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [13:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [14:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[13:0], q_r[29]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[28:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[28:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd29) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- hdl/alr_front.sv -----
// ----------------------------------------------------------------------------
// alr_front: request classifier
// Takes load and step requests, clips and classifies loads, runs the slope
// division and pushes finished requests toward the back end.
// ----------------------------------------------------------------------------
module alr_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic signed [11:0]      in_start_x,
  input  logic signed [11:0]      in_start_y,
  input  logic signed [11:0]      in_end_x,
  input  logic signed [11:0]      in_end_y,
  input  alr_pkg::alr_win_t       win,
  output logic                    req_valid,
  input  logic                    req_ready,
  output alr_pkg::alr_req_t       req
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        st_r, st_nxt;
  alr_pkg::alr_req_t req_r, req_nxt;
  logic              neg_r, neg_nxt;
  logic              div_start;
  logic [29:0]       div_num;
  logic [13:0]       div_den;
  logic              div_done;
  logic [29:0]       div_q;

  logic signed [13:0] ax, ay, bx, by, dx, dy, adx, ady;
  logic signed [13:0] lox, hix, loy, hiy, clox, chix, cloy, chiy;
  logic signed [13:0] smaj, smin, dmin, dmaj, admin;
  logic               drop, xmaj;

  function automatic logic signed [13:0] clampv(input logic signed [13:0] v,
                                                input logic signed [13:0] lo,
                                                input logic signed [13:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  alr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  always_comb begin
    ax  = 14'(in_start_x);
    ay  = 14'(in_start_y);
    bx  = 14'(in_end_x);
    by  = 14'(in_end_y);
    dx  = bx - ax;
    dy  = by - ay;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    lox = ax < bx ? ax : bx;
    hix = ax < bx ? bx : ax;
    loy = ay < by ? ay : by;
    hiy = ay < by ? by : ay;
    clox = clampv(lox, win.x0, win.x1);
    chix = clampv(hix, win.x0, win.x1);
    cloy = clampv(loy, win.y0, win.y1);
    chiy = clampv(hiy, win.y0, win.y1);
    drop = (dx == 0 && dy == 0) || win.x0 > win.x1 || win.y0 > win.y1 ||
           hix < win.x0 || lox > win.x1 || hiy < win.y0 || loy > win.y1;
    xmaj = adx >= ady;
    if (xmaj) begin
      smaj = ax < bx ? ax : bx;
      smin = ax < bx ? ay : by;
      dmin = ax < bx ? dy : -dy;
      dmaj = adx;
    end else begin
      smaj = ay < by ? ay : by;
      smin = ay < by ? ax : bx;
      dmin = ay < by ? dx : -dx;
      dmaj = ady;
    end
    admin   = dmin < 0 ? -dmin : dmin;
    // round half away: (2|dmin|*one + dmaj) / (2*dmaj)
    div_num = ({16'd0, admin} << (alr_pkg::FracBits + 1)) + {16'd0, dmaj};
    div_den = {dmaj[12:0], 1'b0};
  end

  assign in_ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    neg_nxt   = neg_r;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt.is_load = ~in_op;
          req_nxt.mode    = alr_pkg::MODE_IDLE;
          req_nxt.steps   = '0;
          req_nxt.slope   = '0;
          st_nxt          = ST_OUT;
          if (!in_op && !drop) begin
            if (dy == 0) begin
              req_nxt.mode  = alr_pkg::MODE_HSPAN;
              req_nxt.major = clox[12:0];
              req_nxt.minor = 30'(ay);
              req_nxt.steps = 13'(chix - clox + 14'sd1);
            end else if (dx == 0) begin
              req_nxt.mode  = alr_pkg::MODE_VSPAN;
              req_nxt.major = cloy[12:0];
              req_nxt.minor = 30'(ax);
              req_nxt.steps = 13'(chiy - cloy + 14'sd1);
            end else begin
              req_nxt.mode  = xmaj ? alr_pkg::MODE_XMAJOR : alr_pkg::MODE_YMAJOR;
              req_nxt.major = smaj[12:0];
              req_nxt.minor = (30'(smin) <<< alr_pkg::FracBits) +
                              (30'sd1 <<< (alr_pkg::FracBits - 1));
              req_nxt.steps = 13'(dmaj + 14'sd1);
              neg_nxt       = dmin < 0;
              div_start     = 1'b1;
              st_nxt        = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          req_nxt.slope = neg_r ? -18'(div_q) : 18'(div_q);
          st_nxt        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (req_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
    req_r <= req_nxt;
    neg_r <= neg_nxt;
  end

  assign req_valid = (st_r == ST_OUT);
  assign req       = req_r;

endmodule

// ----- hdl/alr_queue.sv -----
// ----------------------------------------------------------------------------
// alr_queue: two-entry request queue
// Decouples the classifier from the stepping back end.
// ----------------------------------------------------------------------------
module alr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  alr_pkg::alr_req_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output alr_pkg::alr_req_t rd_data
);

  alr_pkg::alr_req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- hdl/alr_back.sv -----
// ----------------------------------------------------------------------------
// alr_back: line stepper
// Holds the active line, walks it one position per step request and emits
// up to two clipped fragments through an output register.
// ----------------------------------------------------------------------------
module alr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  alr_pkg::alr_req_t req,
  input  alr_pkg::alr_win_t win,
  input  logic [7:0]        alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [10:0]       out_pixel_x,
  output logic [10:0]       out_pixel_y,
  output logic [7:0]        out_coverage_alpha,
  output logic              out_last,
  output logic              out_line_done
);

  localparam int One  = 1 << alr_pkg::FracBits;
  localparam int Half = One / 2;

  logic [2:0]                              mode_r;
  logic signed [alr_pkg::CoordBits:0]      maj_r;
  logic signed [alr_pkg::PosBits-1:0]      min_r;
  logic signed [alr_pkg::SlopeBits-1:0]    slope_r;
  logic [alr_pkg::StepBits-1:0]            steps_r;

  // pending second fragment
  logic        p2_r;
  logic [10:0] p2x_r, p2y_r;
  logic [7:0]  p2a_r;
  logic        p2done_r;

  logic        ov_r;
  logic [10:0] ox_r, oy_r;
  logic [7:0]  oa_r;
  logic        ol_r, od_r;

  logic signed [13:0] p, p2, fx1, fy1, fx2, fy2;
  logic [alr_pkg::FracBits-1:0] f;
  logic [alr_pkg::FracBits:0]   c1, c2;
  logic        two, in1, in2, fin, take, oslot, fire;
  logic [24:0] m1, m2;

  assign oslot     = !ov_r || out_ready;
  assign req_ready = oslot && !p2_r;
  assign take      = req_valid && req_ready;
  // a step request that puts a fragment into the output register
  assign fire      = take && !req.is_load && mode_r != alr_pkg::MODE_IDLE &&
                     steps_r != '0 && (in1 || in2);

  always_comb begin
    p   = 14'(min_r >>> alr_pkg::FracBits);
    f   = min_r[alr_pkg::FracBits-1:0];
    two = 1'b1;
    c1  = 17'(One);
    c2  = '0;
    p2  = p;
    if (f > 16'(Half)) begin
      c1 = 17'(3 * Half) - {1'b0, f};
      c2 = {1'b0, f} - 17'(Half);
      p2 = p + 14'sd1;
    end else if (f < 16'(Half)) begin
      c1 = 17'(Half) + {1'b0, f};
      c2 = 17'(Half) - {1'b0, f};
      p2 = p - 14'sd1;
    end else begin
      two = 1'b0;
    end
    fx1 = 14'(maj_r); fy1 = p;
    fx2 = 14'(maj_r); fy2 = p2;
    unique case (mode_r)
      alr_pkg::MODE_HSPAN: begin
        fx1 = 14'(maj_r); fy1 = 14'(min_r); c1 = 17'(One); two = 1'b0;
      end
      alr_pkg::MODE_VSPAN: begin
        fx1 = 14'(min_r); fy1 = 14'(maj_r); c1 = 17'(One); two = 1'b0;
      end
      alr_pkg::MODE_YMAJOR: begin
        fx1 = p;  fy1 = 14'(maj_r);
        fx2 = p2; fy2 = 14'(maj_r);
      end
      default: ;
    endcase
    in1 = fx1 >= win.x0 && fx1 <= win.x1 && fy1 >= win.y0 && fy1 <= win.y1;
    in2 = two && fx2 >= win.x0 && fx2 <= win.x1 && fy2 >= win.y0 && fy2 <= win.y1;
    m1  = alpha * c1;
    m2  = alpha * c2;
    fin = steps_r == 13'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= alr_pkg::MODE_IDLE;
      steps_r <= '0;
      p2_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if ((p2_r && oslot) || fire) ov_r <= 1'b1;
      else if (out_ready)          ov_r <= 1'b0;
      if (p2_r && oslot) begin
        ox_r <= p2x_r; oy_r <= p2y_r; oa_r <= p2a_r;
        ol_r <= 1'b1;  od_r <= p2done_r;
        p2_r <= 1'b0;
      end else if (take) begin
        if (req.is_load) begin
          mode_r  <= req.mode;
          maj_r   <= req.major;
          min_r   <= req.minor;
          slope_r <= req.slope;
          steps_r <= req.steps;
        end else if (mode_r != alr_pkg::MODE_IDLE && steps_r != '0) begin
          maj_r   <= maj_r + 13'sd1;
          if (mode_r == alr_pkg::MODE_XMAJOR || mode_r == alr_pkg::MODE_YMAJOR)
            min_r <= min_r + 30'(slope_r);
          steps_r <= steps_r - 13'd1;
          if (fin) mode_r <= alr_pkg::MODE_IDLE;
          if (in1) begin
            ox_r <= fx1[10:0]; oy_r <= fy1[10:0]; oa_r <= m1[23:16];
            ol_r <= !in2; od_r <= !in2 && fin;
            if (in2) begin
              p2_r <= 1'b1;
              p2x_r <= fx2[10:0]; p2y_r <= fy2[10:0]; p2a_r <= m2[23:16];
              p2done_r <= fin;
            end
          end else if (in2) begin
            ox_r <= fx2[10:0]; oy_r <= fy2[10:0]; oa_r <= m2[23:16];
            ol_r <= 1'b1; od_r <= fin;
          end
        end else begin
          mode_r <= alr_pkg::MODE_IDLE;
        end
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_pixel_x        = ox_r;
  assign out_pixel_y        = oy_r;
  assign out_coverage_alpha = oa_r;
  assign out_last           = ol_r;
  assign out_line_done      = od_r;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the antialiased line rasterizer
// Loads and step requests go in through a bursty driver. A request-level
// predictor works out each fragment, and the monitor checks every accepted
// fragment against the oldest prediction. The receiver stalls on its own
// pattern and holds off once for a long stretch. Clip and alpha settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    bit          op;
    logic [11:0] sx, sy, ex, ey;
  } line_req_t;

  typedef struct {
    logic [10:0] x, y;
    logic [7:0]  alpha;
    logic        last, done;
  } frag_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_op;
  logic signed [11:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid, out_ready;
  logic [10:0] out_pixel_x, out_pixel_y;
  logic [7:0] out_coverage_alpha;
  logic out_last, out_line_done;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [11:0] cfg_data;

  antialiased_line_rasterizer dut (.*);

  line_req_t pending[$];
  frag_t     frags_due[$];
  int        errors = 0;
  bit        hold_req = 1'b0;

  // predictor state
  logic [11:0] regs[7];
  logic [2:0]  mode;
  longint      pos_maj, pos_min, slope, steps;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void rasterize(line_req_t r);
    longint one, half, ax, ay, bx, by, dx, dy, x0, x1, y0, y1;
    longint lox, hix, loy, hiy, smaj, smin, dmaj, dmin, num, q;
    longint p, f, p2, c1, c2;
    longint cx[2], cy[2], cc[2];
    int     cand, n;
    bit     two;
    frag_t  fr[2];
    one  = 64'sd1 <<< alr_pkg::FracBits;
    half = one / 2;
    x0 = $signed(regs[alr_pkg::REG_CLIP_L]) < 0 ? 64'sd0 :
         longint'($signed(regs[alr_pkg::REG_CLIP_L]));
    y0 = $signed(regs[alr_pkg::REG_CLIP_T]) < 0 ? 64'sd0 :
         longint'($signed(regs[alr_pkg::REG_CLIP_T]));
    x1 = longint'(regs[alr_pkg::REG_SURF_W]) - 1;
    if (longint'($signed(regs[alr_pkg::REG_CLIP_R])) < x1)
      x1 = longint'($signed(regs[alr_pkg::REG_CLIP_R]));
    y1 = longint'(regs[alr_pkg::REG_SURF_H]) - 1;
    if (longint'($signed(regs[alr_pkg::REG_CLIP_B])) < y1)
      y1 = longint'($signed(regs[alr_pkg::REG_CLIP_B]));

    if (!r.op) begin
      ax = longint'($signed(r.sx)); ay = longint'($signed(r.sy));
      bx = longint'($signed(r.ex)); by = longint'($signed(r.ey));
      dx = bx - ax; dy = by - ay;
      mode = alr_pkg::MODE_IDLE;
      steps = 0;
      if (dx == 0 && dy == 0) return;
      if (x0 > x1 || y0 > y1) return;
      lox = ax < bx ? ax : bx; hix = ax < bx ? bx : ax;
      loy = ay < by ? ay : by; hiy = ay < by ? by : ay;
      if (hix < x0 || lox > x1 || hiy < y0 || loy > y1) return;
      if (lox < x0) lox = x0;
      if (hix > x1) hix = x1;
      if (loy < y0) loy = y0;
      if (hiy > y1) hiy = y1;
      if (dy == 0) begin
        mode = alr_pkg::MODE_HSPAN; pos_maj = lox; pos_min = ay; steps = hix - lox + 1;
        return;
      end
      if (dx == 0) begin
        mode = alr_pkg::MODE_VSPAN; pos_maj = loy; pos_min = ax; steps = hiy - loy + 1;
        return;
      end
      if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
        mode = alr_pkg::MODE_XMAJOR;
        if (ax < bx) begin smaj = ax; smin = ay; dmin = dy; end
        else begin smaj = bx; smin = by; dmin = -dy; end
        dmaj = dx < 0 ? -dx : dx;
      end else begin
        mode = alr_pkg::MODE_YMAJOR;
        if (ay < by) begin smaj = ay; smin = ax; dmin = dx; end
        else begin smaj = by; smin = bx; dmin = -dx; end
        dmaj = dy < 0 ? -dy : dy;
      end
      // round to nearest, ties away from zero
      num = (dmin < 0 ? -dmin : dmin) * one * 2 + dmaj;
      q = num / (dmaj * 2);
      slope = dmin < 0 ? -q : q;
      pos_maj = smaj;
      pos_min = smin * one + half;
      steps = dmaj + 1;
      return;
    end

    if (mode == alr_pkg::MODE_IDLE || steps == 0) begin
      mode = alr_pkg::MODE_IDLE;
      return;
    end
    cand = 1;
    if (mode == alr_pkg::MODE_HSPAN) begin
      cx[0] = pos_maj; cy[0] = pos_min; cc[0] = one;
    end else if (mode == alr_pkg::MODE_VSPAN) begin
      cx[0] = pos_min; cy[0] = pos_maj; cc[0] = one;
    end else begin
      p = pos_min >>> alr_pkg::FracBits;
      f = pos_min - p * one;
      p2 = p; c1 = one; c2 = 0; two = 1'b1;
      if (f > half) begin c1 = 3 * half - f; c2 = f - half; p2 = p + 1; end
      else if (f < half) begin c1 = half + f; c2 = half - f; p2 = p - 1; end
      else two = 1'b0;
      cand = two ? 2 : 1;
      cc[0] = c1; cc[1] = c2;
      if (mode == alr_pkg::MODE_XMAJOR) begin
        cx[0] = pos_maj; cy[0] = p; cx[1] = pos_maj; cy[1] = p2;
      end else begin
        cx[0] = p; cy[0] = pos_maj; cx[1] = p2; cy[1] = pos_maj;
      end
      pos_min += slope;
    end
    pos_maj++;
    steps--;
    n = 0;
    for (int i = 0; i < cand; i++) begin
      if (cx[i] >= x0 && cx[i] <= x1 && cy[i] >= y0 && cy[i] <= y1) begin
        fr[n].x = cx[i][10:0];
        fr[n].y = cy[i][10:0];
        fr[n].alpha = 8'((longint'(regs[alr_pkg::REG_ALPHA]) * cc[i]) >>> alr_pkg::FracBits);
        fr[n].last = 1'b0;
        fr[n].done = 1'b0;
        n++;
      end
    end
    if (n > 0) begin
      fr[n-1].last = 1'b1;
      fr[n-1].done = (steps == 0);
    end
    for (int i = 0; i < n; i++) frags_due.insert(frags_due.size(), fr[i]);
    if (steps == 0) mode = alr_pkg::MODE_IDLE;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    line_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        r = pending.pop_front();
        in_op <= r.op;
        in_start_x <= r.sx; in_start_y <= r.sy;
        in_end_x <= r.ex; in_end_y <= r.ey;
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: shifting stall pattern plus one long hold-off on request
  int hold_cnt = 0, pat_cnt = 0, pat = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else begin
      if (pat_cnt == 0) begin
        pat = $urandom_range(0, 2);
        pat_cnt = $urandom_range(20, 200);
      end
      pat_cnt--;
      case (pat)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // monitor: predict on accepted requests, then check accepted fragments
  always @(posedge clk) begin
    line_req_t r;
    frag_t     e;
    if (rst_n && in_valid && in_ready) begin
      r.op = in_op; r.sx = in_start_x; r.sy = in_start_y;
      r.ex = in_end_x; r.ey = in_end_y;
      rasterize(r);
    end
    if (rst_n && out_valid && out_ready) begin
      if (frags_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected fragment x=%0d y=%0d a=%0d", $realtime,
                 out_pixel_x, out_pixel_y, out_coverage_alpha);
      end else begin
        e = frags_due.pop_front();
        if (out_pixel_x !== e.x || out_pixel_y !== e.y || out_coverage_alpha !== e.alpha
            || out_last !== e.last || out_line_done !== e.done) begin
          errors++;
          $display("%0t: mismatch exp x=%0d y=%0d a=%0d last=%0b done=%0b", $realtime,
                   e.x, e.y, e.alpha, e.last, e.done);
          $display("%0t:          got x=%0d y=%0d a=%0d last=%0b done=%0b", $realtime,
                   out_pixel_x, out_pixel_y, out_coverage_alpha, out_last, out_line_done);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < 7) regs[idx] = idx == alr_pkg::REG_ALPHA ? {4'd0, val[7:0]} : val;
  endtask

  task automatic push_line(int ax, int ay, int bx, int by);
    line_req_t r;
    r.op = 1'b0; r.sx = 12'(ax); r.sy = 12'(ay); r.ex = 12'(bx); r.ey = 12'(by);
    pending.insert(pending.size(), r);
  endtask

  task automatic push_steps(int n);
    line_req_t r;
    r.op = 1'b1;
    for (int i = 0; i < n; i++) begin
      r.sx = 12'($urandom); r.sy = 12'($urandom);
      r.ex = 12'($urandom); r.ey = 12'($urandom);
      pending.insert(pending.size(), r);
    end
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || frags_due.size() != 0) @(posedge clk);
    // a load can still be in the divider
    repeat (60) @(posedge clk);
  endtask

  // well-formed lines near the window, with some noise
  task automatic random_part(int count, int bx0, int by0);
    int ax, ay, ex, ey, len, done_items;
    done_items = 0;
    while (done_items < count) begin
      case ($urandom_range(0, 9))
        0: begin
          push_line($urandom, $urandom, $urandom, $urandom);
          push_steps($urandom_range(0, 3));
          done_items += 3;
        end
        1: begin
          push_steps($urandom_range(1, 3));
          done_items += 2;
        end
        default: begin
          ax = bx0 + $urandom_range(0, 60) - 10;
          ay = by0 + $urandom_range(0, 60) - 10;
          len = $urandom_range(0, 3) == 0 ? 40 : 12;
          ex = ax + $urandom_range(0, 2 * len) - len;
          ey = ay + $urandom_range(0, 2 * len) - len;
          case ($urandom_range(0, 5))
            0: ey = ay;
            1: ex = ax;
            default: ;
          endcase
          push_line(ax, ay, ex, ey);
          len = (ex > ax ? ex - ax : ax - ex) + (ey > ay ? ey - ay : ay - ey);
          len = len / 2 + $urandom_range(0, len / 2 + 3);
          push_steps(len);
          done_items += len + 1;
        end
      endcase
    end
  endtask

  initial begin
    in_valid = 1'b0; in_op = 1'b0;
    in_start_x = '0; in_start_y = '0; in_end_x = '0; in_end_y = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_ready = 1'b0;
    regs[alr_pkg::REG_SURF_W] = 12'd640; regs[alr_pkg::REG_SURF_H] = 12'd480;
    regs[alr_pkg::REG_CLIP_L] = 12'd0; regs[alr_pkg::REG_CLIP_T] = 12'd0;
    regs[alr_pkg::REG_CLIP_R] = 12'd2047; regs[alr_pkg::REG_CLIP_B] = 12'd2047;
    regs[alr_pkg::REG_ALPHA] = 12'd255;
    mode = alr_pkg::MODE_IDLE; pos_maj = 0; pos_min = 0; slope = 0; steps = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle step, extremes, zero length, spans, outside, tie case
    push_steps(1);
    push_line(-2048, -2048, 2047, 2047); push_steps(3);
    push_line(5, 5, 5, 5); push_steps(1);
    push_line(-2048, 10, 2047, 10); push_steps(3);
    push_line(20, 2047, 20, -2048); push_steps(2);
    push_line(700, 10, 900, 20); push_steps(1);
    push_line(10, 10, 14, 12); push_steps(5);
    push_line(30, 3, 20, 0); push_steps(4);
    push_line(2, 8, 0, 20); push_steps(3);
    drain();

    // default window, long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    random_part(300, 0, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(alr_pkg::REG_SURF_W, 12'd2048); write_reg(alr_pkg::REG_SURF_H, 12'd2048);
          write_reg(alr_pkg::REG_CLIP_L, 12'd2000); write_reg(alr_pkg::REG_CLIP_T, 12'd2000);
          write_reg(alr_pkg::REG_CLIP_R, 12'd2047); write_reg(alr_pkg::REG_CLIP_B, 12'd2047);
          write_reg(alr_pkg::REG_ALPHA, 12'd0);
          write_reg(3'd7, 12'hfff);
        end
        1: begin
          write_reg(alr_pkg::REG_SURF_W, 12'd1); write_reg(alr_pkg::REG_SURF_H, 12'd2048);
          write_reg(alr_pkg::REG_CLIP_L, 12'h800); write_reg(alr_pkg::REG_CLIP_T, 12'h800);
          write_reg(alr_pkg::REG_ALPHA, 12'hf80);
        end
        2: begin
          write_reg(alr_pkg::REG_SURF_W, 12'd100); write_reg(alr_pkg::REG_SURF_H, 12'd1);
          write_reg(alr_pkg::REG_CLIP_R, 12'h800); write_reg(alr_pkg::REG_CLIP_B, 12'd40);
        end
        3: begin
          write_reg(alr_pkg::REG_SURF_W, 12'd64); write_reg(alr_pkg::REG_SURF_H, 12'd64);
          write_reg(alr_pkg::REG_CLIP_L, 12'd20); write_reg(alr_pkg::REG_CLIP_T, 12'd30);
          write_reg(alr_pkg::REG_CLIP_R, 12'd40); write_reg(alr_pkg::REG_CLIP_B, 12'd50);
          write_reg(alr_pkg::REG_ALPHA, 12'($urandom_range(1, 254)));
        end
        default: begin
          write_reg(alr_pkg::REG_SURF_W, 12'd500); write_reg(alr_pkg::REG_SURF_H, 12'd300);
          write_reg(alr_pkg::REG_CLIP_L, 12'hff0); write_reg(alr_pkg::REG_CLIP_T, 12'd5);
          write_reg(alr_pkg::REG_CLIP_R, 12'd30); write_reg(alr_pkg::REG_CLIP_B, 12'd4);
          write_reg(alr_pkg::REG_ALPHA, 12'd255);
        end
      endcase
      case (ph)
        0: random_part(280, 1990, 1990);
        1: random_part(150, 0, 0);
        2: random_part(150, 0, 0);
        3: random_part(300, 15, 25);
        default: random_part(100, 0, 0);
      endcase
      drain();
      if (ph == 4) begin
        // back to a usable window for a final random stretch
        write_reg(alr_pkg::REG_CLIP_T, 12'd0); write_reg(alr_pkg::REG_CLIP_B, 12'd2047);
        write_reg(alr_pkg::REG_ALPHA, 12'd77);
        random_part(350, 0, 0);
        drain();
      end
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
